[hdl/adq_pkg.sv]
// ----------------------------------------------------------------------------
// adq_pkg
// Types and constants shared by the array double-ended queue unit.
// ----------------------------------------------------------------------------
`default_nettype none

package adq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int COUNT_W   = 5;

	typedef enum logic [1:0] {
		OP_PUSH_REAR  = 2'd0,
		OP_PUSH_FRONT = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_REAR   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_NOROOM = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef struct packed {
		op_t                        opcode;
		logic signed [DATA_W-1:0]   push_value;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]   pop_data;
		status_t                    status;
		logic [COUNT_W-1:0]         element_count;
		logic signed [DATA_W-1:0]   first_element;
		logic signed [DATA_W-1:0]   last_element;
	} rsp_t;

endpackage

`default_nettype wire

[hdl/adq_ram.sv]
// ----------------------------------------------------------------------------
// adq_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module adq_ram #(
	parameter int WIDTH = adq_pkg::DATA_W,
	parameter int DEPTH = adq_pkg::DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
	output logic      [WIDTH-1:0]         rd_data_a,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic      [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_a_q <= mem_q[rd_addr_a];
		rd_b_q <= mem_q[rd_addr_b];
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

`default_nettype wire

[hdl/array_double_ended_queue_unit.sv]
// ----------------------------------------------------------------------------
// array_double_ended_queue_unit
// Non-circular array deque: push/pop at either end, one result per item.
// ----------------------------------------------------------------------------
// The result of an accepted item is formed combinationally and captured in the
// result register. Throughput: one item per cycle unless rsp_stall holds a
// valid result; the front and rear elements live in registers, and the slot
// RAM prefetches both inner neighbors every cycle. Reset clears the indices,
// count and result valid; slot contents stay undefined until pushed.
`default_nettype none

module array_double_ended_queue_unit #(
	parameter int DEPTH = adq_pkg::DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_stall,
	input  wire adq_pkg::cmd_t cmd,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output adq_pkg::rsp_t      rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic [AW-1:0]               front_q;
	logic [CW-1:0]               cnt_q;
	logic [adq_pkg::DATA_W-1:0]  first_q;
	logic [adq_pkg::DATA_W-1:0]  last_q;
	logic                        rsp_valid_q;
	adq_pkg::rsp_t               rsp_q;

	logic                        accept;
	logic                        full;
	logic [CW-1:0]               end_w;
	logic [AW-1:0]               nf;
	logic [CW-1:0]               ncnt;
	logic [adq_pkg::DATA_W-1:0]  nfirst;
	logic [adq_pkg::DATA_W-1:0]  nlast;
	logic [adq_pkg::DATA_W-1:0]  data;
	adq_pkg::status_t            st;
	logic                        we;
	logic [AW-1:0]               waddr;
	logic [AW-1:0]               rd_front_addr;
	logic [AW-1:0]               rd_rear_addr;
	logic [adq_pkg::DATA_W-1:0]  rd_front;
	logic [adq_pkg::DATA_W-1:0]  rd_rear;
	adq_pkg::rsp_t               res;

	assign accept    = cmd_valid & ~cmd_stall;
	assign cmd_stall = rsp_valid_q & rsp_stall;
	assign full      = (front_q == '0) && (cnt_q == DEPTH_C);
	assign end_w     = CW'(front_q) + cnt_q;

	always_comb begin
		nf     = front_q;
		ncnt   = cnt_q;
		nfirst = first_q;
		nlast  = last_q;
		data   = '0;
		st     = adq_pkg::ST_OK;
		we     = 1'b0;
		waddr  = end_w[AW-1:0];
		if (accept) begin
			unique case (cmd.opcode)
				adq_pkg::OP_PUSH_REAR: begin
					if (full) begin
						st = adq_pkg::ST_FULL;
					end else if (cnt_q != '0 && end_w == DEPTH_C) begin
						st = adq_pkg::ST_NOROOM;
					end else begin
						we    = 1'b1;
						waddr = end_w[AW-1:0];
						ncnt  = cnt_q + CW'(1);
						nlast = cmd.push_value;
						if (cnt_q == '0) begin
							nfirst = cmd.push_value;
						end
					end
				end
				adq_pkg::OP_PUSH_FRONT: begin
					if (full) begin
						st = adq_pkg::ST_FULL;
					end else if (cnt_q == '0) begin
						we     = 1'b1;
						waddr  = '0;
						nf     = '0;
						ncnt   = CW'(1);
						nfirst = cmd.push_value;
						nlast  = cmd.push_value;
					end else if (front_q == '0) begin
						st = adq_pkg::ST_NOROOM;
					end else begin
						we     = 1'b1;
						nf     = front_q - AW'(1);
						waddr  = front_q - AW'(1);
						ncnt   = cnt_q + CW'(1);
						nfirst = cmd.push_value;
					end
				end
				adq_pkg::OP_POP_FRONT: begin
					if (cnt_q == '0) begin
						st = adq_pkg::ST_EMPTY;
					end else begin
						data = first_q;
						ncnt = cnt_q - CW'(1);
						if (cnt_q == CW'(1)) begin
							nf = '0;
						end else begin
							nf     = front_q + AW'(1);
							nfirst = (cnt_q == CW'(2)) ? last_q : rd_front;
						end
					end
				end
				adq_pkg::OP_POP_REAR: begin
					if (cnt_q == '0) begin
						st = adq_pkg::ST_EMPTY;
					end else begin
						data = last_q;
						ncnt = cnt_q - CW'(1);
						if (cnt_q == CW'(1)) begin
							nf = '0;
						end else begin
							nlast = (cnt_q == CW'(2)) ? first_q : rd_rear;
						end
					end
				end
			endcase
		end
	end

	// neighbors of the ends of the next state, ready next cycle
	assign rd_front_addr = nf + AW'(1);
	assign rd_rear_addr  = nf + ncnt[AW-1:0] - AW'(2);

	adq_ram #(
		.WIDTH (adq_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk       (clk),
		.wr_en     (we),
		.wr_addr   (waddr),
		.wr_data   (cmd.push_value),
		.rd_addr_a (rd_front_addr),
		.rd_data_a (rd_front),
		.rd_addr_b (rd_rear_addr),
		.rd_data_b (rd_rear)
	);

	always_comb begin
		res.pop_data      = data;
		res.status        = st;
		res.element_count = adq_pkg::COUNT_W'(ncnt);
		res.first_element = (ncnt == '0) ? '0 : nfirst;
		res.last_element  = (ncnt == '0) ? '0 : nlast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			front_q <= nf;
			cnt_q   <= ncnt;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		first_q <= nfirst;
		last_q  <= nlast;
		if (accept) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
